@@ rtl/core/cbb_pkg.sv @@
// ----------------------------------------------------------------------------
// cbb_pkg
// Shared types and constants for the compacting linear byte buffer.
// ----------------------------------------------------------------------------
package cbb_pkg;

  // Store geometry
  localparam int DEPTH  = 1024;
  localparam int LANES  = 8;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LANE_W = (LANES > 1) ? $clog2(LANES) : 1;

  // Fixed field widths
  localparam int OFS_W  = 11;
  localparam int CNT_W  = 4;
  localparam int DATA_W = 64;

  localparam logic [OFS_W-1:0] DEPTH_OFS = OFS_W'(DEPTH);
  localparam logic [OFS_W-1:0] CAP_RESET = 11'd1024;
  localparam logic [CNT_W-1:0] LANES_CNT = CNT_W'(LANES);

  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_PEEK = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_COMPACT,
    S_PUSH,
    S_POP
  } state_t;

  // One write port and one read port on the byte store
  typedef struct packed {
    logic          we;
    logic [AW-1:0] waddr;
    logic [7:0]    wdata;
    logic          re;
    logic [AW-1:0] raddr;
  } mem_req_t;

endpackage

@@ rtl/core/compacting_linear_byte_buffer.sv @@
// ----------------------------------------------------------------------------
// compacting_linear_byte_buffer
// Linear byte buffer with a read and a write offset and compaction on push.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: present in_op / in_data_in / in_count with start high;
//   the request is taken at an edge where start is high, busy is low and cfg_we is low.
//   Ops: push (append up to 8 bytes), pop (take up to 8 bytes), peek.
//   Result channel: out_valid is high for exactly one cycle with
//   out_done_count, out_data_out, out_fill_level and out_start_offset.
//   The receiver cannot stall; each result must be taken when shown.
//   Per op:
//     peek: result the cycle after the request, busy never rises.
//     push: busy while the bytes are written, and before that while the
//           held bytes have to be moved down to offset 0 first.
//     pop:  busy while the bytes are read back.
//   Busy time follows the byte store: one read and one write port, one
//   byte each way per cycle, with registered read data.
//   A new request can be taken while the previous result is on the ports.
//   Config: cfg_we writes capacity (clipped to the store depth) and empties
//   the buffer; write it only while idle.
//   Reset (rst_n low, synchronous): offsets zero, capacity 1024, no result
//   pending. Store contents are not cleared.
// ----------------------------------------------------------------------------
module compacting_linear_byte_buffer
  import cbb_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // configuration
  input  logic              cfg_we,
  input  logic [OFS_W-1:0]  cfg_wdata,
  // request
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        in_op,
  input  logic [DATA_W-1:0] in_data_in,
  input  logic [CNT_W-1:0]  in_count,
  // result
  output logic              out_valid,
  output logic [CNT_W-1:0]  out_done_count,
  output logic [DATA_W-1:0] out_data_out,
  output logic [OFS_W-1:0]  out_fill_level,
  output logic [OFS_W-1:0]  out_start_offset
);

  // Effective capacity: clipped to the store depth at write time, so the
  // sequencer never sees a value above DEPTH.
  logic [OFS_W-1:0] cap_r, cap_nxt;
  mem_req_t         mem_req;
  logic [7:0]       mem_rdata;

  assign cap_nxt = cfg_we ? ((cfg_wdata > DEPTH_OFS) ? DEPTH_OFS : cfg_wdata) : cap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= (CAP_RESET > DEPTH_OFS) ? DEPTH_OFS : CAP_RESET;
    end else begin
      cap_r <= cap_nxt;
    end
  end

  // Sequencer: offsets, push / pop / compaction walks, result register.
  // A config write while idle also clears both offsets there.
  cbb_ctrl u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .cap              (cap_r),
    .clear            (cfg_we),
    .start            (start),
    .busy             (busy),
    .in_op            (in_op),
    .in_data_in       (in_data_in),
    .in_count         (in_count),
    .mem_req          (mem_req),
    .mem_rdata        (mem_rdata),
    .out_valid        (out_valid),
    .out_done_count   (out_done_count),
    .out_data_out     (out_data_out),
    .out_fill_level   (out_fill_level),
    .out_start_offset (out_start_offset)
  );

  // Byte store, one byte per cycle each way.
  cbb_ram u_ram (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

endmodule

@@ rtl/core/cbb_ram.sv @@
// ----------------------------------------------------------------------------
// cbb_ram
// Byte store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module cbb_ram
  import cbb_pkg::*;
(
  input  logic       clk,
  input  mem_req_t   req,
  output logic [7:0] rdata
);

  logic [7:0] mem_q [DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem_q[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata <= mem_q[req.raddr];
    end
  end

endmodule

@@ rtl/core/cbb_ctrl.sv @@
// ----------------------------------------------------------------------------
// cbb_ctrl
// Request sequencer: offsets, push/pop/compaction walks, result register.
// ----------------------------------------------------------------------------
module cbb_ctrl
  import cbb_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic [OFS_W-1:0]  cap,
  input  logic              clear,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        in_op,
  input  logic [DATA_W-1:0] in_data_in,
  input  logic [CNT_W-1:0]  in_count,
  output mem_req_t          mem_req,
  input  logic [7:0]        mem_rdata,
  output logic              out_valid,
  output logic [CNT_W-1:0]  out_done_count,
  output logic [DATA_W-1:0] out_data_out,
  output logic [OFS_W-1:0]  out_fill_level,
  output logic [OFS_W-1:0]  out_start_offset
);

  state_t              state_r, state_nxt;
  logic [OFS_W-1:0]    ro_r, ro_nxt;
  logic [OFS_W-1:0]    wo_r, wo_nxt;
  logic [OFS_W-1:0]    cnt_r, cnt_nxt;
  logic [OFS_W-1:0]    held_r, held_nxt;
  logic [OFS_W-1:0]    pend_r, pend_nxt;
  logic                rvalid_r, rvalid_nxt;
  logic [CNT_W-1:0]    n_r, n_nxt;
  logic [CNT_W-1:0]    neff_r, neff_nxt;
  logic [DATA_W-1:0]   data_r, data_nxt;
  logic [DATA_W-1:0]   acc_r, acc_nxt;
  logic                ov_r, ov_nxt;
  logic [CNT_W-1:0]    od_r, od_nxt;
  logic [DATA_W-1:0]   odata_r, odata_nxt;
  logic [OFS_W-1:0]    ofill_r, ofill_nxt;
  logic [OFS_W-1:0]    ostart_r, ostart_nxt;

  logic [CNT_W-1:0]    n_sat;
  logic [OFS_W-1:0]    room, held_now, room_cmp, neff_ext;
  logic [OFS_W-1:0]    rd_ptr, wr_ptr, wo_push, ro_pop;

  assign n_sat    = (in_count > LANES_CNT) ? LANES_CNT : in_count;
  assign room     = cap - wo_r;
  assign held_now = wo_r - ro_r;
  assign room_cmp = cap - held_r;
  assign neff_ext = OFS_W'(neff_r);
  assign rd_ptr   = ro_r + cnt_r;
  assign wr_ptr   = wo_r + cnt_r;
  assign wo_push  = wo_r + neff_ext;
  assign ro_pop   = ro_r + neff_ext;

  always_comb begin
    state_nxt  = state_r;
    ro_nxt     = ro_r;
    wo_nxt     = wo_r;
    cnt_nxt    = cnt_r;
    held_nxt   = held_r;
    pend_nxt   = pend_r;
    rvalid_nxt = 1'b0;
    n_nxt      = n_r;
    neff_nxt   = neff_r;
    data_nxt   = data_r;
    acc_nxt    = acc_r;
    ov_nxt     = 1'b0;
    od_nxt     = od_r;
    odata_nxt  = odata_r;
    ofill_nxt  = ofill_r;
    ostart_nxt = ostart_r;
    mem_req    = '0;

    unique case (state_r)
      S_IDLE: begin
        if (clear) begin
          ro_nxt = '0;
          wo_nxt = '0;
        end else if (start) begin
          data_nxt = in_data_in;
          n_nxt    = n_sat;
          cnt_nxt  = '0;
          acc_nxt  = '0;
          unique case (op_t'(in_op))
            OP_PUSH: begin
              if ((room < OFS_W'(n_sat)) && (ro_r != '0)) begin
                held_nxt  = held_now;
                state_nxt = S_COMPACT;
              end else begin
                neff_nxt  = (room < OFS_W'(n_sat)) ? CNT_W'(room) : n_sat;
                state_nxt = S_PUSH;
              end
            end
            OP_POP: begin
              neff_nxt  = (held_now < OFS_W'(n_sat)) ? CNT_W'(held_now) : n_sat;
              state_nxt = S_POP;
            end
            default: begin
              // peek and the unused code
              ov_nxt     = 1'b1;
              od_nxt     = '0;
              odata_nxt  = '0;
              ofill_nxt  = held_now;
              ostart_nxt = ro_r;
            end
          endcase
        end
      end

      S_COMPACT: begin
        // read ro+k, write k in the cycle after; writes stay below reads
        if (cnt_r < held_r) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = rd_ptr[AW-1:0];
          cnt_nxt       = cnt_r + 1'b1;
          rvalid_nxt    = 1'b1;
        end
        pend_nxt = cnt_r;
        if (rvalid_r) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = pend_r[AW-1:0];
          mem_req.wdata = mem_rdata;
        end
        if ((cnt_r == held_r) && !rvalid_r) begin
          ro_nxt    = '0;
          wo_nxt    = held_r;
          cnt_nxt   = '0;
          neff_nxt  = (room_cmp < OFS_W'(n_r)) ? CNT_W'(room_cmp) : n_r;
          state_nxt = S_PUSH;
        end
      end

      S_PUSH: begin
        if (cnt_r < neff_ext) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = wr_ptr[AW-1:0];
          mem_req.wdata = data_r[7:0];
          data_nxt      = data_r >> 8;
          cnt_nxt       = cnt_r + 1'b1;
        end else begin
          wo_nxt     = wo_push;
          ov_nxt     = 1'b1;
          od_nxt     = neff_r;
          odata_nxt  = '0;
          ofill_nxt  = wo_push - ro_r;
          ostart_nxt = ro_r;
          state_nxt  = S_IDLE;
        end
      end

      S_POP: begin
        if (cnt_r < neff_ext) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = rd_ptr[AW-1:0];
          cnt_nxt       = cnt_r + 1'b1;
          rvalid_nxt    = 1'b1;
        end
        pend_nxt = cnt_r;
        if (rvalid_r) begin
          acc_nxt[8*pend_r[LANE_W-1:0] +: 8] = mem_rdata;
        end
        if ((cnt_r == neff_ext) && !rvalid_r) begin
          ro_nxt     = ro_pop;
          ov_nxt     = 1'b1;
          od_nxt     = neff_r;
          odata_nxt  = acc_r;
          ofill_nxt  = wo_r - ro_pop;
          ostart_nxt = ro_pop;
          state_nxt  = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ro_r     <= '0;
      wo_r     <= '0;
      rvalid_r <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ro_r     <= ro_nxt;
      wo_r     <= wo_nxt;
      rvalid_r <= rvalid_nxt;
      ov_r     <= ov_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    cnt_r    <= cnt_nxt;
    held_r   <= held_nxt;
    pend_r   <= pend_nxt;
    n_r      <= n_nxt;
    neff_r   <= neff_nxt;
    data_r   <= data_nxt;
    acc_r    <= acc_nxt;
    od_r     <= od_nxt;
    odata_r  <= odata_nxt;
    ofill_r  <= ofill_nxt;
    ostart_r <= ostart_nxt;
  end

  assign busy             = (state_r != S_IDLE);
  assign out_valid        = ov_r;
  assign out_done_count   = od_r;
  assign out_data_out     = odata_r;
  assign out_fill_level   = ofill_r;
  assign out_start_offset = ostart_r;

  // write offset never passes the capacity
  a_wo_cap: assert property (@(posedge clk) disable iff (!rst_n)
    wo_r <= cap) else $error("write offset above capacity");

  // read offset never passes the write offset
  a_ro_wo: assert property (@(posedge clk) disable iff (!rst_n)
    ro_r <= wo_r) else $error("read offset above write offset");

  // compaction never reads and writes the same entry in one cycle
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_req.we && mem_req.re) |-> (mem_req.waddr != mem_req.raddr))
    else $error("read/write overlap on byte store");

  // a reported level fits in the capacity and a reported count in the lanes
  a_fill_cap: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> ((ofill_r <= cap) && (od_r <= LANES_CNT)))
    else $error("result level or count out of range");

endmodule
